@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL file of the cache lookup block.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property in every cycle.
`define EWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define EWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ewc_lfu_pkg.sv @@
// Package of the eight-way LFU cache lookup: field widths and size defaults.
// No dependencies; used by the channel interfaces and the top level.
package ewc_lfu_pkg;

    localparam int ADDR_W        = 64;
    localparam int WAY_OUT_W     = 3;
    localparam int SET_OUT_W     = 7;
    localparam int TOTAL_W       = 32;

    localparam int DEF_SETS        = 128;
    localparam int DEF_WAYS        = 8;
    localparam int DEF_OFFSET_BITS = 6;
    localparam int DEF_COUNT_BITS  = 32;

endpackage

@@ sv/ewc_lfu_if.sv @@
// Valid/ready channel interfaces of the LFU cache lookup: request and response.
// Depends on ewc_lfu_pkg for the field widths.
interface ewc_lfu_req_if;
    logic                             valid;
    logic                             ready;
    logic [ewc_lfu_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface ewc_lfu_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [ewc_lfu_pkg::WAY_OUT_W-1:0]  way;
    logic [ewc_lfu_pkg::SET_OUT_W-1:0]  set_index;
    logic [ewc_lfu_pkg::TOTAL_W-1:0]    hit_count;
    logic [ewc_lfu_pkg::TOTAL_W-1:0]    miss_count;

    modport source (output valid, output hit, output way, output set_index,
                    output hit_count, output miss_count, input ready);
    modport sink   (input valid, input hit, input way, input set_index,
                    input hit_count, input miss_count, output ready);
endinterface

@@ sv/eight_way_cache_lfu_lookup.sv @@
// Set-associative cache lookup with least-frequently-used replacement.
// Depends on ewc_lfu_pkg, ewc_lfu_if.sv (channel interfaces) and assert_macros.svh.
//
// Channel | Dir | Payload                                          | Transfer
// --------+-----+--------------------------------------------------+----------------------
// req     | in  | address[63:0]                                    | req.valid & req.ready
// rsp     | out | hit, way[2:0], set_index[6:0], hit_count[31:0],  | rsp.valid & rsp.ready
//         |     | miss_count[31:0]                                 |
//
// Cycles: two per item. The transfer edge reads the set's row from the set memory;
// the next edge compares all ways, writes the row back and loads the result register.
// The single-port read-modify-write of one row per item sets this figure.
// Reset: after rst_n rises, a clearing pass writes one zero row per cycle for SETS
// cycles (128 at the default size); req.ready stays low during the pass.
// Stalls: a new item is taken while a result waits in the output register; the
// lookup then holds its write-back until the output register is free.
`include "assert_macros.svh"

module eight_way_cache_lfu_lookup #(
    parameter int SETS        = ewc_lfu_pkg::DEF_SETS,
    parameter int WAYS        = ewc_lfu_pkg::DEF_WAYS,
    parameter int OFFSET_BITS = ewc_lfu_pkg::DEF_OFFSET_BITS,
    parameter int COUNT_BITS  = ewc_lfu_pkg::DEF_COUNT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    ewc_lfu_req_if.sink        req,
    ewc_lfu_rsp_if.source      rsp
);

    localparam int ADDR_W   = ewc_lfu_pkg::ADDR_W;
    localparam int TOTAL_W  = ewc_lfu_pkg::TOTAL_W;
    // Set index field: smallest number of address bits that covers SETS.
    localparam int IDX_BITS = $clog2(SETS);
    localparam int SET_W    = (IDX_BITS == 0) ? 1 : IDX_BITS;
    localparam int TAG_W    = ADDR_W - OFFSET_BITS - IDX_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'd1 << IDX_BITS) - 64'd1);
    localparam logic [SET_W:0]   SETS_WIDE = (SET_W + 1)'(SETS);
    localparam logic [SET_W-1:0] SET_LAST  = SET_W'(SETS - 1);

    // One memory row holds every way of a set: tags and use counts.
    typedef struct packed {
        logic [WAYS-1:0][COUNT_BITS-1:0] counts;
        logic [WAYS-1:0][TAG_W-1:0]      tags;
    } row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Set memory
    row_t             mem [SETS];
    row_t             mem_rdata_reg;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    row_t             mem_wdata;

    // Control and payload registers
    state_t               state_reg;
    logic [SET_W-1:0]     clr_idx_reg;
    logic [SET_W-1:0]     set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [TOTAL_W-1:0]   hits_total_reg;
    logic [TOTAL_W-1:0]   misses_total_reg;
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [ewc_lfu_pkg::WAY_OUT_W-1:0] out_way_reg;
    logic [ewc_lfu_pkg::SET_OUT_W-1:0] out_set_reg;

    // Request decode
    logic [ADDR_W-1:0]    line;
    logic [SET_W-1:0]     raw_set;
    logic [SET_W-1:0]     in_set;
    logic [TAG_W-1:0]     in_tag;
    logic                 req_xfer;

    // Lookup
    logic [WAYS-1:0]      match;
    logic [WAYS-1:0]      is_min;
    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     victim_way;
    logic [WAY_W-1:0]     chosen;
    row_t                 row_next;
    logic                 lookup_done;
    logic [TOTAL_W-1:0]   hits_total_next;
    logic [TOTAL_W-1:0]   misses_total_next;

    // Split the address into set and tag; fold an out-of-range set back once.
    always_comb
    begin
        line    = req.address >> OFFSET_BITS;
        raw_set = line[SET_W-1:0] & SET_MASK;
        if ({1'b0, raw_set} >= SETS_WIDE)
        begin
            in_set = raw_set - SETS_WIDE[SET_W-1:0];
        end
        else
        begin
            in_set = raw_set;
        end
        in_tag = TAG_W'(line >> IDX_BITS);
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_xfer    = req.valid && req.ready;
    // Write back only when the output register can take the result.
    assign lookup_done = (state_reg == ST_LOOKUP) && (!out_valid_reg || rsp.ready);

    // Tag compare, first hit and least-used victim (lowest index wins a tie).
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = (mem_rdata_reg.tags[w] == tag_reg);
        end
        hit = |match;

        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
        end

        // Way i is the victim when it is below every earlier way and not above
        // any later way: exactly one way meets that.
        for (int i = 0; i < WAYS; i++)
        begin
            is_min[i] = 1'b1;
            for (int j = 0; j < WAYS; j++)
            begin
                if (j < i)
                begin
                    if (!(mem_rdata_reg.counts[i] < mem_rdata_reg.counts[j]))
                    begin
                        is_min[i] = 1'b0;
                    end
                end
                else if (j > i)
                begin
                    if (mem_rdata_reg.counts[i] > mem_rdata_reg.counts[j])
                    begin
                        is_min[i] = 1'b0;
                    end
                end
            end
        end

        victim_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (is_min[w])
            begin
                victim_way = WAY_W'(w);
            end
        end

        chosen   = hit ? hit_way : victim_way;
        row_next = mem_rdata_reg;
        if (hit)
        begin
            // Saturate the use count at all ones.
            if (mem_rdata_reg.counts[chosen] != '1)
            begin
                row_next.counts[chosen] = mem_rdata_reg.counts[chosen] + COUNT_BITS'(1);
            end
        end
        else
        begin
            row_next.tags[chosen]   = tag_reg;
            row_next.counts[chosen] = '0;
        end

        hits_total_next   = hits_total_reg;
        misses_total_next = misses_total_reg;
        if (hit)
        begin
            if (hits_total_reg != '1)
            begin
                hits_total_next = hits_total_reg + TOTAL_W'(1);
            end
        end
        else
        begin
            if (misses_total_reg != '1)
            begin
                misses_total_next = misses_total_reg + TOTAL_W'(1);
            end
        end
    end

    // Memory write port: zero rows during the clearing pass, else the write-back.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = row_next;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
            end
            ST_LOOKUP:
            begin
                mem_we = lookup_done;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Set memory: one write port, one registered read port. Reads happen only on
    // a request transfer, which never shares an edge with a write, so the read
    // data holds through an output stall.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (req_xfer)
        begin
            mem_rdata_reg <= mem[in_set];
        end
    end

    // Sequencer, totals and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            hits_total_reg   <= '0;
            misses_total_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_hit_reg      <= 1'b0;
            out_way_reg      <= '0;
            out_set_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    // Sweep every row once after reset.
                    clr_idx_reg <= clr_idx_reg + SET_W'(1);
                    if (clr_idx_reg == SET_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_xfer)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (lookup_done)
                    begin
                        state_reg        <= ST_IDLE;
                        hits_total_reg   <= hits_total_next;
                        misses_total_reg <= misses_total_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Load a new result, or drop the one just transferred.
            if (lookup_done)
            begin
                out_valid_reg <= 1'b1;
                out_hit_reg   <= hit;
                out_way_reg   <= ewc_lfu_pkg::WAY_OUT_W'(chosen);
                out_set_reg   <= ewc_lfu_pkg::SET_OUT_W'(set_reg);
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.way        = out_way_reg;
    assign rsp.set_index  = out_set_reg;
    assign rsp.hit_count  = hits_total_reg;
    assign rsp.miss_count = misses_total_reg;

    `EWC_ASSERT_NEXT(a_xfer_starts_lookup, req_xfer, state_reg == ST_LOOKUP,
                     "request transfer did not start a lookup")
    `EWC_ASSERT_NEXT(a_hits_monotonic, 1'b1, hits_total_reg >= $past(hits_total_reg),
                     "hit total decreased")
    `EWC_ASSERT_NEXT(a_one_total_moves,
                     lookup_done && hits_total_reg != '1 && misses_total_reg != '1,
                     $countones({hits_total_reg != $past(hits_total_reg),
                                 misses_total_reg != $past(misses_total_reg)}) == 1,
                     "lookup did not advance exactly one total")
    `EWC_ASSERT(a_no_result_in_clear, (state_reg == ST_CLEAR) |-> !rsp.valid,
                "result shown during clearing pass")

endmodule
